@@ hw/rtl/ftta_pkg.sv @@
// Shared constants, request and status codes, and the token type for the flow table.
`timescale 1ns / 1ps

package ftta_pkg;

   // Table depth and derived count width
   localparam int ENTRIES = 64;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // Fixed field widths
   localparam int ADDRS_W    = 64;
   localparam int PP_W       = 40;
   localparam int TIME_W     = 32;
   localparam int INTERVAL_W = 31;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 7;
   localparam int PADDR_W    = 3;

   // Configuration register
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 31'd1000;
   localparam logic                  REG_INTERVAL   = 1'b0;

   // Request codes
   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // Request token that walks down the row of cells
   typedef struct packed {
      logic               vld;
      logic [OP_W-1:0]    op;
      logic [ADDRS_W-1:0] addrs;
      logic [PP_W-1:0]    pp;
      logic [TIME_W-1:0]  tm;
      logic               sweep;
      logic               done;
      logic [CNT_W-1:0]   removed;
   } tok_type;

endpackage

@@ hw/rtl/flow_tuple_table_with_aging_core.sv @@
// Top level: request head, row of entry cells, result tail and configuration register.
`timescale 1ns / 1ps

// Flow tuple table with aging.
// Requests (insert, peek, remove, clear, tick) enter on start while busy is
// low; busy stays low, so an item can be taken on every clock cycle.
// Each item walks down a row of ENTRIES cells, one cell per cycle; each cell
// owns one table entry, so the lowest free slot and the lowest match are
// found as the item passes. Items stay in order, and every item yields one
// result on the rsp_ ports, marked by rsp_valid for exactly one cycle.
// Results come out through the head register, the ENTRIES cells and the result register.
// Throughput: one item per cycle. The receiver cannot stall results.
// Time and the sweep period advance when a tick is accepted; a tick that
// completes a period carries a sweep flag that ages out old entries as it
// passes each cell.
// Reset clears all valid bits, time, period count and occupancy, and loads
// interval_ticks with 1000. The user writes interval_ticks over the APB port
// (byte address 0) only while no item is in flight; the block does not check.
module flow_tuple_table_with_aging_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ftta_pkg::OP_W-1:0]        req_type,
   input  logic [31:0]                      req_src_addr,
   input  logic [31:0]                      req_dst_addr,
   input  logic [15:0]                      req_src_port,
   input  logic [15:0]                      req_dst_port,
   input  logic [7:0]                       req_proto,
   output logic                             rsp_valid,
   output logic [ftta_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ftta_pkg::COUNT_W-1:0]     rsp_removed_count,
   output logic [ftta_pkg::COUNT_W-1:0]     rsp_occupancy,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ftta_pkg::PADDR_W-1:0]     paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   logic                            accept;
   logic                            is_tick;
   logic                            sweep_now;
   logic [ftta_pkg::TIME_W-1:0]     time_ff;
   logic [ftta_pkg::TIME_W-1:0]     time_in;
   logic [ftta_pkg::TIME_W-1:0]     time_inc;
   logic [ftta_pkg::TIME_W-1:0]     period_ff;
   logic [ftta_pkg::TIME_W-1:0]     period_in;
   logic [ftta_pkg::TIME_W-1:0]     period_inc;
   logic [ftta_pkg::INTERVAL_W-1:0] interval_ff;
   logic [ftta_pkg::INTERVAL_W-1:0] interval_in;
   logic                            csr_write;
   ftta_pkg::tok_type               head_ff;
   ftta_pkg::tok_type               head_in;
   ftta_pkg::tok_type               link [0:ftta_pkg::ENTRIES];
   ftta_pkg::tok_type               tail;
   logic                            inserted;
   logic [ftta_pkg::CNT_W-1:0]      occ_ff;
   logic [ftta_pkg::CNT_W-1:0]      occ_in;
   logic [ftta_pkg::STATUS_W-1:0]   status_in;
   logic                            rsp_valid_ff;
   logic [ftta_pkg::STATUS_W-1:0]   rsp_status_ff;
   logic [ftta_pkg::COUNT_W-1:0]    rsp_removed_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign pready = 1'b1;

   // Configuration register write and read back
   assign csr_write   = psel && penable && pwrite && pready &&
                        (paddr[2] == ftta_pkg::REG_INTERVAL);
   assign interval_in = csr_write ? pwdata[ftta_pkg::INTERVAL_W-1:0] : interval_ff;
   assign prdata      = (paddr[2] == ftta_pkg::REG_INTERVAL) ? {1'b0, interval_ff} : 32'd0;

   // Advance time and period count on tick
   assign is_tick    = (req_type == ftta_pkg::OP_TICK);
   assign time_inc   = time_ff + 32'd1;
   assign period_inc = period_ff + 32'd1;
   assign sweep_now  = (period_inc >= {1'b0, interval_ff});
   assign time_in    = (accept && is_tick) ? time_inc : time_ff;
   assign period_in  = (accept && is_tick) ? (sweep_now ? 32'd0 : period_inc) : period_ff;

   // Build the token for the accepted item
   always_comb begin
      head_in.vld     = accept;
      head_in.op      = req_type;
      head_in.addrs   = {req_src_addr, req_dst_addr};
      head_in.pp      = {req_src_port, req_dst_port, req_proto};
      head_in.tm      = is_tick ? time_inc : time_ff;
      head_in.sweep   = is_tick && sweep_now;
      head_in.done    = 1'b0;
      head_in.removed = '0;
   end

   // Row of entry cells
   assign link[0] = head_ff;

   genvar gi;
   generate
      for (gi = 0; gi < ftta_pkg::ENTRIES; gi++) begin : g_cell
         ftta_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .interval (interval_ff),
            .up_tok   (link[gi]),
            .dn_tok   (link[gi+1])
         );
      end
   endgenerate

   assign tail = link[ftta_pkg::ENTRIES];

   // Resolve status and occupancy at the end of the row
   assign inserted = tail.vld && (tail.op == ftta_pkg::OP_INSERT) && tail.done;

   always_comb begin
      unique case (tail.op)
         ftta_pkg::OP_INSERT: status_in = tail.done ? ftta_pkg::ST_OK : ftta_pkg::ST_FULL;
         ftta_pkg::OP_PEEK:   status_in = tail.done ? ftta_pkg::ST_OK : ftta_pkg::ST_MISS;
         ftta_pkg::OP_REMOVE: status_in = tail.done ? ftta_pkg::ST_OK : ftta_pkg::ST_MISS;
         default:             status_in = ftta_pkg::ST_OK;
      endcase
   end

   assign occ_in = tail.vld ?
                   (occ_ff + ftta_pkg::CNT_W'(inserted) - tail.removed) : occ_ff;

   // Control state and head token
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         period_ff    <= '0;
         interval_ff  <= ftta_pkg::INTERVAL_RESET;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         period_ff    <= period_in;
         interval_ff  <= interval_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= tail.vld;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_status_ff  <= status_in;
      rsp_removed_ff <= ftta_pkg::COUNT_W'(tail.removed);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_occupancy     = ftta_pkg::COUNT_W'(occ_ff);

   // Occupancy never exceeds the table size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= ftta_pkg::CNT_W'(ftta_pkg::ENTRIES))
      else $error("occupancy above table size");

   // A failed insert only happens with every slot taken
   a_full_real: assert property (@(posedge clock) disable iff (reset)
      (tail.vld && (tail.op == ftta_pkg::OP_INSERT) && !tail.done)
      |-> (occ_ff == ftta_pkg::CNT_W'(ftta_pkg::ENTRIES)))
      else $error("table full reported with free slots");

   // Clear leaves the table empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (tail.vld && (tail.op == ftta_pkg::OP_CLEAR)) |=> (occ_ff == '0))
      else $error("occupancy not zero after clear");

   // Remove deletes exactly one entry on a hit and none on a miss
   a_remove_one: assert property (@(posedge clock) disable iff (reset)
      (tail.vld && (tail.op == ftta_pkg::OP_REMOVE))
      |-> (tail.removed == ftta_pkg::CNT_W'(tail.done)))
      else $error("remove deleted a wrong number of entries");

   // Peek and insert never delete
   a_no_delete: assert property (@(posedge clock) disable iff (reset)
      (tail.vld && ((tail.op == ftta_pkg::OP_PEEK) || (tail.op == ftta_pkg::OP_INSERT)))
      |-> (tail.removed == '0))
      else $error("lookup or insert deleted entries");

endmodule

@@ hw/rtl/ftta_cell.sv @@
// One table entry: holds a tuple, its stamp and valid bit, and applies each passing item.
`timescale 1ns / 1ps

module ftta_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ftta_pkg::INTERVAL_W-1:0] interval,
   input  ftta_pkg::tok_type               up_tok,
   output ftta_pkg::tok_type               dn_tok
);

   logic                         valid_ff;
   logic                         valid_in;
   logic [ftta_pkg::ADDRS_W-1:0] addrs_ff;
   logic [ftta_pkg::ADDRS_W-1:0] addrs_in;
   logic [ftta_pkg::PP_W-1:0]    pp_ff;
   logic [ftta_pkg::PP_W-1:0]    pp_in;
   logic [ftta_pkg::TIME_W-1:0]  stamp_ff;
   logic [ftta_pkg::TIME_W-1:0]  stamp_in;
   ftta_pkg::tok_type            tok_ff;
   ftta_pkg::tok_type            tok_in;
   logic                         write_en;
   logic                         match;
   logic [ftta_pkg::TIME_W-1:0]  age;
   logic                         aged;

   // Compare the entry with the passing tuple and check its age
   assign match = valid_ff && (addrs_ff == up_tok.addrs) && (pp_ff == up_tok.pp);
   assign age   = up_tok.tm - stamp_ff;
   assign aged  = valid_ff && (age > {1'b0, interval});

   // Apply the item to this entry and update the token
   always_comb begin
      tok_in   = up_tok;
      valid_in = valid_ff;
      write_en = 1'b0;
      if (up_tok.vld) begin
         unique case (up_tok.op)
            ftta_pkg::OP_INSERT: begin
               if (!up_tok.done && !valid_ff) begin
                  valid_in    = 1'b1;
                  write_en    = 1'b1;
                  tok_in.done = 1'b1;
               end
            end
            ftta_pkg::OP_PEEK: begin
               if (match) begin
                  tok_in.done = 1'b1;
               end
            end
            ftta_pkg::OP_REMOVE: begin
               if (!up_tok.done && match) begin
                  valid_in       = 1'b0;
                  tok_in.done    = 1'b1;
                  tok_in.removed = up_tok.removed + ftta_pkg::CNT_W'(1);
               end
            end
            ftta_pkg::OP_CLEAR: begin
               if (valid_ff) begin
                  valid_in       = 1'b0;
                  tok_in.removed = up_tok.removed + ftta_pkg::CNT_W'(1);
               end
            end
            ftta_pkg::OP_TICK: begin
               if (up_tok.sweep && aged) begin
                  valid_in       = 1'b0;
                  tok_in.removed = up_tok.removed + ftta_pkg::CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Load the entry payload on insert
   assign addrs_in = write_en ? up_tok.addrs : addrs_ff;
   assign pp_in    = write_en ? up_tok.pp    : pp_ff;
   assign stamp_in = write_en ? up_tok.tm    : stamp_ff;

   // Control state and token hand-off
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      addrs_ff <= addrs_in;
      pp_ff    <= pp_in;
      stamp_ff <= stamp_in;
   end

   assign dn_tok = tok_ff;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the flow tuple table with aging: directed table, random phases.
`timescale 1ns / 1ps

module testbench;
   import ftta_pkg::*;

   // Request codes with no defined meaning
   localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

   localparam logic [PADDR_W-1:0] CSR_INTERVAL_ADDR = {REG_INTERVAL, 2'b00};
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX   = 31'h7FFF_FFFF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 175;
   localparam int KEY_BITS     = 104;
   localparam int POOL_SIZE    = 8;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  proto;
   } flow_key_t;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  removed_count;
      logic [COUNT_W-1:0]  occupancy;
   } flow_reply_t;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

   typedef struct {
      row_kind_t             kind;
      logic [OP_W-1:0]       op;
      flow_key_t             key;
      int                    reps;
      bit                    typed;
      flow_reply_t           reply;
      logic [INTERVAL_W-1:0] interval;
   } stim_row_t;

   // Block ports
   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_type = '0;
   logic [31:0]           req_src_addr = '0;
   logic [31:0]           req_dst_addr = '0;
   logic [15:0]           req_src_port = '0;
   logic [15:0]           req_dst_port = '0;
   logic [7:0]            req_proto = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_removed_count;
   logic [COUNT_W-1:0]    rsp_occupancy;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_W-1:0]    paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // Shadow of the flow table
   bit                    flow_valid [ENTRIES];
   logic [ADDRS_W-1:0]    flow_addrs [ENTRIES];
   logic [PP_W-1:0]       flow_pp [ENTRIES];
   logic [TIME_W-1:0]     flow_stamp [ENTRIES];
   logic [TIME_W-1:0]     now_ticks = '0;
   logic [TIME_W-1:0]     period_ticks = '0;
   logic [INTERVAL_W-1:0] interval_cfg = INTERVAL_RESET;

   flow_reply_t pending_replies[$];
   stim_row_t   stim_table[$];
   flow_key_t   key_pool [POOL_SIZE];
   int          mismatches = 0;
   int          quiet_cycles = 0;
   int          idle_pct = 0;

   flow_tuple_table_with_aging_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_src_addr      (req_src_addr),
      .req_dst_addr      (req_dst_addr),
      .req_src_port      (req_src_port),
      .req_dst_port      (req_dst_port),
      .req_proto         (req_proto),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_removed_count (rsp_removed_count),
      .rsp_occupancy     (rsp_occupancy),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one request to the shadow table and return its reply
   function automatic flow_reply_t predict_request(logic [OP_W-1:0] op, flow_key_t key);
      logic [ADDRS_W-1:0] addrs;
      logic [PP_W-1:0]    pp;
      logic [TIME_W-1:0]  age;
      flow_reply_t        r;
      int                 hit;
      int                 slot;
      int                 occ;
      addrs = {key.src_addr, key.dst_addr};
      pp    = {key.src_port, key.dst_port, key.proto};
      r.status        = ST_OK;
      r.removed_count = '0;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && flow_valid[i] && flow_addrs[i] == addrs && flow_pp[i] == pp)
            hit = i;
         if (slot < 0 && !flow_valid[i])
            slot = i;
      end
      case (op)
         OP_INSERT: begin
            if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               flow_valid[slot] = 1'b1;
               flow_addrs[slot] = addrs;
               flow_pp[slot]    = pp;
               flow_stamp[slot] = now_ticks;
            end
         end
         OP_PEEK: begin
            if (hit < 0) r.status = ST_MISS;
         end
         OP_REMOVE: begin
            if (hit < 0) begin
               r.status = ST_MISS;
            end else begin
               flow_valid[hit] = 1'b0;
               r.removed_count = 7'd1;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (flow_valid[i]) r.removed_count = r.removed_count + 1'b1;
               flow_valid[i] = 1'b0;
            end
         end
         OP_TICK: begin
            now_ticks    = now_ticks + 1'b1;
            period_ticks = period_ticks + 1'b1;
            // Sweep once the period completes; ages wrap modulo 2^32
            if (period_ticks >= {1'b0, interval_cfg}) begin
               period_ticks = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  age = now_ticks - flow_stamp[i];
                  if (flow_valid[i] && age > {1'b0, interval_cfg}) begin
                     flow_valid[i]   = 1'b0;
                     r.removed_count = r.removed_count + 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
      occ = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (flow_valid[i]) occ++;
      r.occupancy = occ[COUNT_W-1:0];
      return r;
   endfunction

   function automatic flow_key_t random_key();
      return {$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
   endfunction

   // Present one item, hold it until accepted, then record what it should return
   task automatic send_item(input logic [OP_W-1:0] op, input flow_key_t key,
                            input bit typed, input flow_reply_t typed_reply);
      flow_reply_t predicted;
      int          gap;
      start        <= 1'b1;
      req_type     <= op;
      req_src_addr <= key.src_addr;
      req_dst_addr <= key.dst_addr;
      req_src_port <= key.src_port;
      req_dst_port <= key.dst_port;
      req_proto    <= key.proto;
      do @(posedge clock); while (busy);
      predicted = predict_request(op, key);
      pending_replies.push_back(typed ? typed_reply : predicted);
      // Idle the sender at random
      gap = 0;
      while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold the sender off until every outstanding item has answered
   task automatic drain_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // Write interval_ticks over APB while idle, then read it back
   task automatic write_interval(input logic [INTERVAL_W-1:0] value);
      logic [31:0] readback;
      drain_replies();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_INTERVAL_ADDR;
      pwdata  <= {1'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      interval_cfg = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== {1'b0, value}) begin
         $display("%0t: interval readback expected %0d actual %0d", $time, value, readback);
         mismatches++;
      end
   endtask

   task automatic add_item(input logic [OP_W-1:0] op, input flow_key_t key, input int reps);
      stim_row_t row;
      row = '{kind: ROW_ITEM, op: op, key: key, reps: reps, typed: 1'b0,
              reply: '0, interval: '0};
      stim_table.push_back(row);
   endtask

   task automatic add_typed(input logic [OP_W-1:0] op, input flow_key_t key,
                            input logic [STATUS_W-1:0] status,
                            input int removed, input int occ);
      stim_row_t row;
      row = '{kind: ROW_ITEM, op: op, key: key, reps: 1, typed: 1'b1,
              reply: {status, removed[COUNT_W-1:0], occ[COUNT_W-1:0]}, interval: '0};
      stim_table.push_back(row);
   endtask

   task automatic add_cfg(input logic [INTERVAL_W-1:0] value);
      stim_row_t row;
      row = '{kind: ROW_CFG, op: OP_TICK, key: '0, reps: 0, typed: 1'b0,
              reply: '0, interval: value};
      stim_table.push_back(row);
   endtask

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      flow_reply_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_replies.size() == 0) begin
            $display("%0t: unexpected result status %0d removed %0d occupancy %0d",
                     $time, rsp_status, rsp_removed_count, rsp_occupancy);
            mismatches++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               mismatches++;
            end
            if (rsp_removed_count !== want.removed_count) begin
               $display("%0t: removed_count expected %0d actual %0d",
                        $time, want.removed_count, rsp_removed_count);
               mismatches++;
            end
            if (rsp_occupancy !== want.occupancy) begin
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_occupancy);
               mismatches++;
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      flow_key_t             zero_key;
      flow_key_t             ones_key;
      flow_key_t             near_ones;
      flow_key_t             mid_key;
      flow_key_t             key;
      stim_row_t             row;
      logic [OP_W-1:0]       op;
      logic [INTERVAL_W-1:0] interval;
      int                    pick;
      int                    insert_lim;
      int                    clear_pct;

      for (int i = 0; i < ENTRIES; i++) begin
         flow_valid[i] = 1'b0;
         flow_addrs[i] = '0;
         flow_pp[i]    = '0;
         flow_stamp[i] = '0;
      end

      zero_key  = '0;
      ones_key  = '1;
      near_ones = '1;
      near_ones.proto = 8'hFE;
      mid_key   = {32'hC0A8_0001, 32'h0A00_0001, 16'd1024, 16'd80, 8'd6};

      // Directed part: extremes, every request, full table, sweeps
      add_typed(OP_PEEK,   zero_key,  ST_MISS, 0, 0);
      add_typed(OP_REMOVE, ones_key,  ST_MISS, 0, 0);
      add_typed(OP_INSERT, zero_key,  ST_OK,   0, 1);
      add_typed(OP_INSERT, ones_key,  ST_OK,   0, 2);
      add_typed(OP_INSERT, ones_key,  ST_OK,   0, 3);
      add_typed(OP_PEEK,   ones_key,  ST_OK,   0, 3);
      add_typed(OP_REMOVE, ones_key,  ST_OK,   1, 2);
      add_typed(OP_PEEK,   ones_key,  ST_OK,   0, 2);
      add_typed(OP_PEEK,   near_ones, ST_MISS, 0, 2);
      add_typed(OP_TICK,   zero_key,  ST_OK,   0, 2);
      add_typed(OP_RSVD_5, ones_key,  ST_OK,   0, 2);
      add_typed(OP_RSVD_6, zero_key,  ST_OK,   0, 2);
      add_typed(OP_RSVD_7, ones_key,  ST_OK,   0, 2);
      add_item(OP_INSERT, mid_key, ENTRIES - 2);
      add_typed(OP_INSERT, ones_key,  ST_FULL, 0, ENTRIES);
      add_typed(OP_REMOVE, zero_key,  ST_OK,   1, ENTRIES - 1);
      add_typed(OP_INSERT, zero_key,  ST_OK,   0, ENTRIES);
      add_typed(OP_CLEAR,  ones_key,  ST_OK,   ENTRIES, 0);
      add_typed(OP_CLEAR,  zero_key,  ST_OK,   0, 0);
      add_cfg(31'd2);
      add_item(OP_INSERT, mid_key, 1);
      add_item(OP_TICK, zero_key, 3);
      // Zero interval sweeps on every tick
      add_cfg(31'd0);
      add_item(OP_INSERT, ones_key, 1);
      add_item(OP_TICK, zero_key, 2);
      // Raised interval, then lowered below the count already reached, so the tick after it sweeps
      add_cfg(INTERVAL_RESET);
      add_item(OP_INSERT, mid_key, 2);
      add_item(OP_TICK, zero_key, 5);
      add_cfg(31'd3);
      add_item(OP_TICK, zero_key, 1);
      add_cfg(INTERVAL_MAX);
      add_item(OP_INSERT, zero_key, 1);
      add_item(OP_TICK, zero_key, 1);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      foreach (stim_table[r]) begin
         row = stim_table[r];
         if (row.kind == ROW_CFG) begin
            write_interval(row.interval);
         end else begin
            for (int k = 0; k < row.reps; k++) begin
               key = row.key;
               key.src_addr = key.src_addr + k;
               key.dst_port = key.dst_port ^ k[15:0];
               send_item(row.op, key, row.typed, row.reply);
            end
         end
      end

      // Random phases: each with its own interval, idling and request mix
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 5)
            0:       interval = 31'd1;
            1:       interval = 31'($urandom_range(12, 2));
            2:       interval = INTERVAL_MAX;
            3:       interval = 31'($urandom_range(80, 13));
            default: interval = INTERVAL_RESET;
         endcase
         write_interval(interval);
         case (ph % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 66;
            default: idle_pct = 10;
         endcase
         clear_pct  = (ph % 2 == 0) ? 0 : 2;
         insert_lim = (clear_pct == 0) ? 45 : 34;
         foreach (key_pool[i]) key_pool[i] = random_key();

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Pick a request
            pick = $urandom_range(99);
            if (pick < insert_lim)
               op = OP_INSERT;
            else if (pick < insert_lim + 20)
               op = OP_PEEK;
            else if (pick < insert_lim + 38)
               op = OP_REMOVE;
            else if (pick < 97 - clear_pct)
               op = OP_TICK;
            else if (pick < 97)
               op = OP_CLEAR;
            else
               op = OP_RSVD_5 + OP_W'($urandom_range(2));
            // Mostly pooled tuples, some one bit off, some fully random
            pick = $urandom_range(99);
            key  = key_pool[$urandom_range(POOL_SIZE - 1)];
            if (pick >= 90)
               key = random_key();
            else if (pick >= 80)
               key = key ^ (KEY_BITS'(1) << $urandom_range(KEY_BITS - 1));
            send_item(op, key, 1'b0, '0);
            // Pause now and then until the table has answered everything
            if ($urandom_range(249) == 0) drain_replies();
         end
      end

      drain_replies();
      repeat (ENTRIES + 8) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
